@@ sv/qapm_pkg.sv @@
// shared types, codes and microprogram for the quadrotor attitude pd mixer
package qapm_pkg;

	localparam int NSLOT = 22;
	localparam int NCFG = 8;

	localparam logic [30:0] CFG_RESET [NCFG] = '{
		31'd102748, 31'd2278, 31'd2278, 31'd6403,
		31'd14090, 31'd1049, 31'd65536, 31'd642908
	};

	localparam logic [2:0] OP_ADD  = 3'd0;
	localparam logic [2:0] OP_SUB  = 3'd1;
	localparam logic [2:0] OP_MUL  = 3'd2;
	localparam logic [2:0] OP_DIV  = 3'd3;
	localparam logic [2:0] OP_SQRT = 3'd4;
	localparam logic [2:0] OP_OUT  = 3'd5;

	typedef struct packed {
		logic [2:0] op;
		logic [5:0] dst;
		logic [6:0] a;
		logic [6:0] b;
	} instr_t;

	typedef struct packed {
		logic go;
		logic sqrt_op;
	} iter_req_t;

	typedef struct packed {
		logic done;
		logic sat;
	} iter_rsp_t;

	typedef struct packed {
		logic        sat;
		logic [31:0] val;
	} clip_t;

	// operand words
	localparam logic [6:0] W_PX = 7'd0;
	localparam logic [6:0] W_PY = 7'd1;
	localparam logic [6:0] W_PZ = 7'd2;
	localparam logic [6:0] W_VX = 7'd3;
	localparam logic [6:0] W_VY = 7'd4;
	localparam logic [6:0] W_VZ = 7'd5;
	localparam logic [6:0] W_QW = 7'd6;
	localparam logic [6:0] W_QX = 7'd7;
	localparam logic [6:0] W_QY = 7'd8;
	localparam logic [6:0] W_QZ = 7'd9;
	localparam logic [6:0] W_RP = 7'd10;
	localparam logic [6:0] W_RQ = 7'd11;
	localparam logic [6:0] W_RR = 7'd12;
	localparam logic [6:0] W_TPX = 7'd13;
	localparam logic [6:0] W_TPY = 7'd14;
	localparam logic [6:0] W_TPZ = 7'd15;
	localparam logic [6:0] W_TVX = 7'd16;
	localparam logic [6:0] W_TVY = 7'd17;
	localparam logic [6:0] W_TVZ = 7'd18;
	localparam logic [6:0] W_TRP = 7'd19;
	localparam logic [6:0] W_TRQ = 7'd20;
	localparam logic [6:0] W_TRR = 7'd21;

	// scratch words
	localparam logic [6:0] A_EX   = 7'd22;
	localparam logic [6:0] A_EY   = 7'd23;
	localparam logic [6:0] A_EZ   = 7'd24;
	localparam logic [6:0] A_EVX  = 7'd25;
	localparam logic [6:0] A_EVY  = 7'd26;
	localparam logic [6:0] A_EVZ  = 7'd27;
	localparam logic [6:0] A_EP   = 7'd28;
	localparam logic [6:0] A_EQ   = 7'd29;
	localparam logic [6:0] A_ER   = 7'd30;
	localparam logic [6:0] A_T1   = 7'd31;
	localparam logic [6:0] A_T2   = 7'd32;
	localparam logic [6:0] A_DX   = 7'd33;
	localparam logic [6:0] A_DY   = 7'd34;
	localparam logic [6:0] A_DZ   = 7'd35;
	localparam logic [6:0] A_DZG  = 7'd36;
	localparam logic [6:0] A_NRM  = 7'd37;
	localparam logic [6:0] A_R1   = 7'd38;
	localparam logic [6:0] A_QDW  = 7'd39;
	localparam logic [6:0] A_S    = 7'd40;
	localparam logic [6:0] A_C    = 7'd41;
	localparam logic [6:0] A_DEN2 = 7'd42;
	localparam logic [6:0] A_QDX  = 7'd43;
	localparam logic [6:0] A_QDY  = 7'd44;
	localparam logic [6:0] A_QE1  = 7'd45;
	localparam logic [6:0] A_QE2  = 7'd46;
	localparam logic [6:0] A_QE3  = 7'd47;
	localparam logic [6:0] A_QE4  = 7'd48;
	localparam logic [6:0] A_DPHI = 7'd49;
	localparam logic [6:0] A_DTH  = 7'd50;
	localparam logic [6:0] A_DPSI = 7'd51;
	localparam logic [6:0] A_THR  = 7'd52;
	localparam logic [6:0] A_TPHI = 7'd53;
	localparam logic [6:0] A_TTH  = 7'd54;
	localparam logic [6:0] A_TPSI = 7'd55;
	localparam logic [6:0] A_SQ2  = 7'd56;
	localparam logic [6:0] A_BD4  = 7'd57;
	localparam logic [6:0] A_CT   = 7'd58;
	localparam logic [6:0] A_CPHI = 7'd59;
	localparam logic [6:0] A_CTH  = 7'd60;
	localparam logic [6:0] A_CPSI = 7'd61;
	localparam logic [6:0] A_F0   = 7'd22;
	localparam logic [6:0] A_F1   = 7'd23;
	localparam logic [6:0] A_F2   = 7'd24;
	localparam logic [6:0] A_F3   = 7'd25;

	// register and constant sources, bit 6 set
	localparam logic [6:0] C_MASS  = 7'd64;
	localparam logic [6:0] C_IXX   = 7'd65;
	localparam logic [6:0] C_IYY   = 7'd66;
	localparam logic [6:0] C_IZZ   = 7'd67;
	localparam logic [6:0] C_ARM   = 7'd68;
	localparam logic [6:0] C_KDRAG = 7'd69;
	localparam logic [6:0] C_BSC   = 7'd70;
	localparam logic [6:0] C_GRAV  = 7'd71;
	localparam logic [6:0] K_03    = 7'd72;
	localparam logic [6:0] K_09    = 7'd73;
	localparam logic [6:0] K_4     = 7'd74;
	localparam logic [6:0] K_5     = 7'd75;
	localparam logic [6:0] K_10    = 7'd76;
	localparam logic [6:0] K_3     = 7'd77;
	localparam logic [6:0] K_17    = 7'd78;
	localparam logic [6:0] K_05    = 7'd79;
	localparam logic [6:0] K_ONE   = 7'd80;
	localparam logic [6:0] K_TWO   = 7'd81;

	localparam logic [6:0] SRC_NONE = 7'd0;
	localparam logic [6:0] RTR0 = 7'd0;
	localparam logic [6:0] RTR1 = 7'd1;
	localparam logic [6:0] RTR2 = 7'd2;
	localparam logic [6:0] RTR3 = 7'd3;

	localparam logic [1:0] ROTOR_LAST = 2'd3;

	function automatic clip_t clip65(input logic signed [64:0] v);
		clip_t r;
		if (v > 65'sh0_7FFF_FFFF) begin
			r.sat = 1'b1;
			r.val = 32'h7FFF_FFFF;
		end else if (v < -65'sh0_8000_0000) begin
			r.sat = 1'b1;
			r.val = 32'h8000_0000;
		end else begin
			r.sat = 1'b0;
			r.val = v[31:0];
		end
		return r;
	endfunction

	function automatic instr_t mk(input logic [2:0] op, input logic [6:0] d,
		input logic [6:0] a, input logic [6:0] b);
		instr_t r;
		r.op = op;
		r.dst = d[5:0];
		r.a = a;
		r.b = b;
		return r;
	endfunction

	function automatic instr_t prog(input logic [6:0] pc);
		instr_t r;
		case (pc)
			7'd0:   r = mk(OP_SUB, A_EX, W_TPX, W_PX);
			7'd1:   r = mk(OP_SUB, A_EY, W_TPY, W_PY);
			7'd2:   r = mk(OP_SUB, A_EZ, W_TPZ, W_PZ);
			7'd3:   r = mk(OP_SUB, A_EVX, W_TVX, W_VX);
			7'd4:   r = mk(OP_SUB, A_EVY, W_TVY, W_VY);
			7'd5:   r = mk(OP_SUB, A_EVZ, W_TVZ, W_VZ);
			7'd6:   r = mk(OP_SUB, A_EP, W_TRP, W_RP);
			7'd7:   r = mk(OP_SUB, A_EQ, W_TRQ, W_RQ);
			7'd8:   r = mk(OP_SUB, A_ER, W_TRR, W_RR);
			7'd9:   r = mk(OP_MUL, A_T1, K_03, A_EX);
			7'd10:  r = mk(OP_MUL, A_T2, K_09, A_EVX);
			7'd11:  r = mk(OP_ADD, A_DX, A_T1, A_T2);
			7'd12:  r = mk(OP_MUL, A_T1, K_03, A_EY);
			7'd13:  r = mk(OP_MUL, A_T2, K_09, A_EVY);
			7'd14:  r = mk(OP_ADD, A_DY, A_T1, A_T2);
			7'd15:  r = mk(OP_MUL, A_T1, K_4, A_EZ);
			7'd16:  r = mk(OP_MUL, A_T2, K_5, A_EVZ);
			7'd17:  r = mk(OP_ADD, A_DZ, A_T1, A_T2);
			7'd18:  r = mk(OP_ADD, A_DZG, A_DZ, C_GRAV);
			7'd19:  r = mk(OP_MUL, A_T1, A_DX, A_DX);
			7'd20:  r = mk(OP_MUL, A_T2, A_DY, A_DY);
			7'd21:  r = mk(OP_ADD, A_T1, A_T1, A_T2);
			7'd22:  r = mk(OP_MUL, A_T2, A_DZG, A_DZG);
			7'd23:  r = mk(OP_ADD, A_T1, A_T1, A_T2);
			7'd24:  r = mk(OP_SQRT, A_NRM, A_T1, SRC_NONE);
			7'd25:  r = mk(OP_ADD, A_T1, A_NRM, A_NRM);
			7'd26:  r = mk(OP_DIV, A_R1, A_DZG, A_T1);
			7'd27:  r = mk(OP_ADD, A_T1, K_05, A_R1);
			7'd28:  r = mk(OP_MUL, A_T2, W_QZ, W_QZ);
			7'd29:  r = mk(OP_SUB, A_T1, A_T1, A_T2);
			7'd30:  r = mk(OP_SQRT, A_QDW, A_T1, SRC_NONE);
			7'd31:  r = mk(OP_MUL, A_T1, W_QW, W_QW);
			7'd32:  r = mk(OP_ADD, A_S, A_T1, A_T2);
			7'd33:  r = mk(OP_ADD, A_T1, A_S, A_S);
			7'd34:  r = mk(OP_SUB, A_C, A_T1, K_ONE);
			7'd35:  r = mk(OP_ADD, A_T1, A_DZG, A_DZG);
			7'd36:  r = mk(OP_MUL, A_DEN2, A_T1, A_S);
			7'd37:  r = mk(OP_MUL, A_T1, A_DX, W_QZ);
			7'd38:  r = mk(OP_MUL, A_T2, A_DY, W_QW);
			7'd39:  r = mk(OP_SUB, A_T1, A_T1, A_T2);
			7'd40:  r = mk(OP_MUL, A_T1, A_T1, A_C);
			7'd41:  r = mk(OP_DIV, A_QDX, A_T1, A_DEN2);
			7'd42:  r = mk(OP_MUL, A_T1, A_DX, W_QW);
			7'd43:  r = mk(OP_MUL, A_T2, A_DY, W_QZ);
			7'd44:  r = mk(OP_ADD, A_T1, A_T1, A_T2);
			7'd45:  r = mk(OP_MUL, A_T1, A_T1, A_C);
			7'd46:  r = mk(OP_DIV, A_QDY, A_T1, A_DEN2);
			7'd47:  r = mk(OP_MUL, A_T1, A_QDX, W_QW);
			7'd48:  r = mk(OP_MUL, A_T2, A_QDW, W_QX);
			7'd49:  r = mk(OP_SUB, A_T1, A_T1, A_T2);
			7'd50:  r = mk(OP_MUL, A_T2, A_QDY, W_QZ);
			7'd51:  r = mk(OP_ADD, A_QE1, A_T1, A_T2);
			7'd52:  r = mk(OP_MUL, A_T1, A_QDY, W_QW);
			7'd53:  r = mk(OP_MUL, A_T2, A_QDW, W_QY);
			7'd54:  r = mk(OP_SUB, A_T1, A_T1, A_T2);
			7'd55:  r = mk(OP_MUL, A_T2, A_QDX, W_QZ);
			7'd56:  r = mk(OP_SUB, A_QE2, A_T1, A_T2);
			7'd57:  r = mk(OP_MUL, A_T1, A_QDX, W_QY);
			7'd58:  r = mk(OP_MUL, A_T2, A_QDY, W_QX);
			7'd59:  r = mk(OP_SUB, A_T1, A_T1, A_T2);
			7'd60:  r = mk(OP_MUL, A_T2, A_QDW, W_QZ);
			7'd61:  r = mk(OP_SUB, A_QE3, A_T1, A_T2);
			7'd62:  r = mk(OP_MUL, A_T1, A_QDX, W_QX);
			7'd63:  r = mk(OP_MUL, A_T2, A_QDY, W_QY);
			7'd64:  r = mk(OP_ADD, A_T1, A_T1, A_T2);
			7'd65:  r = mk(OP_MUL, A_T2, A_QDW, W_QW);
			7'd66:  r = mk(OP_ADD, A_QE4, A_T1, A_T2);
			7'd67:  r = mk(OP_MUL, A_T1, K_10, A_QE1);
			7'd68:  r = mk(OP_MUL, A_T1, A_T1, A_QE4);
			7'd69:  r = mk(OP_MUL, A_T2, K_5, A_EP);
			7'd70:  r = mk(OP_ADD, A_DPHI, A_T1, A_T2);
			7'd71:  r = mk(OP_MUL, A_T1, K_10, A_QE2);
			7'd72:  r = mk(OP_MUL, A_T1, A_T1, A_QE4);
			7'd73:  r = mk(OP_MUL, A_T2, K_5, A_EQ);
			7'd74:  r = mk(OP_ADD, A_DTH, A_T1, A_T2);
			7'd75:  r = mk(OP_MUL, A_T1, K_3, A_QE3);
			7'd76:  r = mk(OP_MUL, A_T1, A_T1, A_QE4);
			7'd77:  r = mk(OP_MUL, A_T2, K_17, A_ER);
			7'd78:  r = mk(OP_ADD, A_DPSI, A_T1, A_T2);
			7'd79:  r = mk(OP_MUL, A_T1, C_MASS, A_DZG);
			7'd80:  r = mk(OP_DIV, A_THR, A_T1, A_C);
			7'd81:  r = mk(OP_MUL, A_TPHI, A_DPHI, C_IXX);
			7'd82:  r = mk(OP_MUL, A_TTH, A_DTH, C_IYY);
			7'd83:  r = mk(OP_MUL, A_TPSI, A_DPSI, C_IZZ);
			7'd84:  r = mk(OP_SQRT, A_SQ2, K_TWO, SRC_NONE);
			7'd85:  r = mk(OP_MUL, A_T1, C_BSC, C_ARM);
			7'd86:  r = mk(OP_MUL, A_BD4, A_T1, K_4);
			7'd87:  r = mk(OP_MUL, A_T1, C_BSC, K_4);
			7'd88:  r = mk(OP_DIV, A_CT, A_THR, A_T1);
			7'd89:  r = mk(OP_MUL, A_T1, A_SQ2, A_TPHI);
			7'd90:  r = mk(OP_DIV, A_CPHI, A_T1, A_BD4);
			7'd91:  r = mk(OP_MUL, A_T1, A_SQ2, A_TTH);
			7'd92:  r = mk(OP_DIV, A_CTH, A_T1, A_BD4);
			7'd93:  r = mk(OP_MUL, A_T1, C_KDRAG, K_4);
			7'd94:  r = mk(OP_DIV, A_CPSI, A_TPSI, A_T1);
			7'd95:  r = mk(OP_ADD, A_T1, A_CT, A_CPSI);
			7'd96:  r = mk(OP_SUB, A_T1, A_T1, A_CTH);
			7'd97:  r = mk(OP_ADD, A_F0, A_T1, A_CPHI);
			7'd98:  r = mk(OP_SUB, A_T1, A_CT, A_CPSI);
			7'd99:  r = mk(OP_SUB, A_T1, A_T1, A_CTH);
			7'd100: r = mk(OP_SUB, A_F1, A_T1, A_CPHI);
			7'd101: r = mk(OP_ADD, A_T1, A_CT, A_CPSI);
			7'd102: r = mk(OP_ADD, A_T1, A_T1, A_CTH);
			7'd103: r = mk(OP_SUB, A_F2, A_T1, A_CPHI);
			7'd104: r = mk(OP_SUB, A_T1, A_CT, A_CPSI);
			7'd105: r = mk(OP_ADD, A_T1, A_T1, A_CTH);
			7'd106: r = mk(OP_ADD, A_F3, A_T1, A_CPHI);
			7'd107: r = mk(OP_OUT, RTR0, A_F0, SRC_NONE);
			7'd108: r = mk(OP_OUT, RTR1, A_F1, SRC_NONE);
			7'd109: r = mk(OP_OUT, RTR2, A_F2, SRC_NONE);
			default: r = mk(OP_OUT, RTR3, A_F3, SRC_NONE);
		endcase
		return r;
	endfunction

endpackage

@@ sv/quadrotor_attitude_pd_mixer_unit.sv @@
// quadrotor attitude pd controller with x mixer: top level
// a word with last low is stored and busy stays low.
// a word with last high starts an update, run by 111 microcode steps through one
// scratch memory; each of the eight divides runs in the shared digit-serial unit.
// four force words then follow on res_strobe; the receiver cannot stall them.
// reset marks the operand words unwritten, so they read as zero, and loads the register defaults.
module quadrotor_attitude_pd_mixer_unit #(
	parameter int FRAC_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [4:0]         slot,
	input  logic signed [31:0] operand_value,
	input  logic               last,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_idx,
	input  logic [30:0]        cfg_data,
	output logic               res_strobe,
	output logic [1:0]         rotor,
	output logic signed [31:0] force_res,
	output logic               saturated,
	output logic               final_res
);

	localparam int ONE = 1 << FRAC_BITS;
	localparam logic [31:0] KV_03  = 32'((3 * ONE + 5) / 10);
	localparam logic [31:0] KV_09  = 32'((9 * ONE + 5) / 10);
	localparam logic [31:0] KV_4   = 32'(4 * ONE);
	localparam logic [31:0] KV_5   = 32'(5 * ONE);
	localparam logic [31:0] KV_10  = 32'(10 * ONE);
	localparam logic [31:0] KV_3   = 32'(3 * ONE);
	localparam logic [31:0] KV_17  = 32'((17 * ONE + 5) / 10);
	localparam logic [31:0] KV_05  = 32'((ONE + 1) / 2);
	localparam logic [31:0] KV_ONE = 32'(ONE);
	localparam logic [31:0] KV_TWO = 32'(2 * ONE);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_RD   = 3'd1;
	localparam logic [2:0] ST_EX   = 3'd2;
	localparam logic [2:0] ST_MUL  = 3'd3;
	localparam logic [2:0] ST_WT   = 3'd4;

	logic [2:0]  state_q;
	logic [6:0]  pc_q;
	logic        sat_q;
	logic [30:0] cfg_q [qapm_pkg::NCFG];
	logic [qapm_pkg::NSLOT-1:0] opv_q;

	logic [31:0] mem [64];
	logic [31:0] rd_a_q;
	logic [31:0] rd_b_q;
	logic        va_s1;
	logic        vb_s1;
	logic signed [63:0] prod_s1;

	logic        res_strobe_q;
	logic [1:0]  rotor_q;
	logic [31:0] force_q;
	logic        sat_out_q;
	logic        final_q;

	qapm_pkg::instr_t    ins;
	qapm_pkg::iter_req_t ireq;
	qapm_pkg::iter_rsp_t irsp;
	logic [31:0]         ires;

	logic        accept;
	logic [31:0] opa;
	logic [31:0] opb;
	logic signed [64:0] sum_w;
	logic signed [64:0] rnd_w;
	logic signed [64:0] shr_w;
	qapm_pkg::clip_t add_c;
	qapm_pkg::clip_t mul_c;

	logic        mem_we;
	logic [5:0]  mem_wa;
	logic [31:0] mem_wd;

	function automatic logic [31:0] kval(input logic [4:0] idx,
		input logic [30:0] cv);
		logic [31:0] r;
		case (idx)
			5'd8:    r = KV_03;
			5'd9:    r = KV_09;
			5'd10:   r = KV_4;
			5'd11:   r = KV_5;
			5'd12:   r = KV_10;
			5'd13:   r = KV_3;
			5'd14:   r = KV_17;
			5'd15:   r = KV_05;
			5'd16:   r = KV_ONE;
			5'd17:   r = KV_TWO;
			default: r = {1'b0, cv};
		endcase
		return r;
	endfunction

	assign ins = qapm_pkg::prog(pc_q);
	assign accept = start && (state_q == ST_IDLE);
	assign busy = (state_q != ST_IDLE);

	assign opa = ins.a[6] ? kval(ins.a[4:0], cfg_q[ins.a[2:0]]) : (va_s1 ? rd_a_q : 32'd0);
	assign opb = ins.b[6] ? kval(ins.b[4:0], cfg_q[ins.b[2:0]]) : (vb_s1 ? rd_b_q : 32'd0);

	assign sum_w = (ins.op == qapm_pkg::OP_SUB) ?
		($signed({{33{opa[31]}}, opa}) - $signed({{33{opb[31]}}, opb})) :
		($signed({{33{opa[31]}}, opa}) + $signed({{33{opb[31]}}, opb}));
	assign add_c = qapm_pkg::clip65(sum_w);

	// round half up, then floor shift
	assign rnd_w = $signed({prod_s1[63], prod_s1}) + (65'sd1 <<< (FRAC_BITS - 1));
	assign shr_w = rnd_w >>> FRAC_BITS;
	assign mul_c = qapm_pkg::clip65(shr_w);

	assign ireq.go = (state_q == ST_EX) &&
		((ins.op == qapm_pkg::OP_DIV) || (ins.op == qapm_pkg::OP_SQRT));
	assign ireq.sqrt_op = (ins.op == qapm_pkg::OP_SQRT);

	qapm_iter #(
		.FRAC_BITS(FRAC_BITS)
	) u_iter (
		.clk(clk),
		.arst_n(arst_n),
		.req(ireq),
		.a(opa),
		.b(opb),
		.rsp(irsp),
		.result(ires)
	);

	always_comb begin
		mem_we = 1'b0;
		mem_wa = ins.dst;
		mem_wd = add_c.val;
		case (state_q)
			ST_IDLE: begin
				mem_we = accept && (slot < 5'(qapm_pkg::NSLOT));
				mem_wa = {1'b0, slot};
				mem_wd = operand_value;
			end
			ST_EX: begin
				mem_we = (ins.op == qapm_pkg::OP_ADD) || (ins.op == qapm_pkg::OP_SUB);
			end
			ST_MUL: begin
				mem_we = 1'b1;
				mem_wd = mul_c.val;
			end
			ST_WT: begin
				mem_we = irsp.done;
				mem_wd = ires;
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	// each step writes back before the next step reads, so no forwarding is needed
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		rd_a_q <= mem[ins.a[5:0]];
		rd_b_q <= mem[ins.b[5:0]];
		va_s1 <= (ins.a[5:0] < 6'(qapm_pkg::NSLOT)) ? opv_q[ins.a[4:0]] : 1'b1;
		vb_s1 <= (ins.b[5:0] < 6'(qapm_pkg::NSLOT)) ? opv_q[ins.b[4:0]] : 1'b1;
		prod_s1 <= $signed(opa) * $signed(opb);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pc_q <= '0;
			sat_q <= 1'b0;
			opv_q <= '0;
			res_strobe_q <= 1'b0;
			for (int i = 0; i < qapm_pkg::NCFG; i++) begin
				cfg_q[i] <= qapm_pkg::CFG_RESET[i];
			end
		end else begin
			res_strobe_q <= 1'b0;
			if (cfg_we) begin
				cfg_q[cfg_idx] <= cfg_data;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (slot < 5'(qapm_pkg::NSLOT)) begin
							opv_q[slot] <= 1'b1;
						end
						if (last) begin
							state_q <= ST_RD;
							pc_q <= '0;
							sat_q <= 1'b0;
						end
					end
				end
				ST_RD: begin
					state_q <= ST_EX;
				end
				ST_EX: begin
					case (ins.op)
						qapm_pkg::OP_ADD, qapm_pkg::OP_SUB: begin
							sat_q <= sat_q | add_c.sat;
							pc_q <= pc_q + 7'd1;
							state_q <= ST_RD;
						end
						qapm_pkg::OP_MUL: begin
							state_q <= ST_MUL;
						end
						qapm_pkg::OP_DIV, qapm_pkg::OP_SQRT: begin
							state_q <= ST_WT;
						end
						default: begin
							res_strobe_q <= 1'b1;
							if (ins.dst[1:0] == qapm_pkg::ROTOR_LAST) begin
								state_q <= ST_IDLE;
							end else begin
								pc_q <= pc_q + 7'd1;
								state_q <= ST_RD;
							end
						end
					endcase
				end
				ST_MUL: begin
					sat_q <= sat_q | mul_c.sat;
					pc_q <= pc_q + 7'd1;
					state_q <= ST_RD;
				end
				ST_WT: begin
					if (irsp.done) begin
						sat_q <= sat_q | irsp.sat;
						pc_q <= pc_q + 7'd1;
						state_q <= ST_RD;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_EX) && (ins.op == qapm_pkg::OP_OUT)) begin
			rotor_q <= ins.dst[1:0];
			force_q <= opa;
			sat_out_q <= sat_q;
			final_q <= (ins.dst[1:0] == qapm_pkg::ROTOR_LAST);
		end
	end

	assign res_strobe = res_strobe_q;
	assign rotor = rotor_q;
	assign force_res = force_q;
	assign saturated = sat_out_q;
	assign final_res = final_q;

`ifndef NO_ASSERTIONS
	a_mid_word_busy: assert property (@(posedge clk) disable iff (!arst_n)
		res_strobe && !final_res |-> busy)
		else $error("force word out of a run");
	a_final_idle: assert property (@(posedge clk) disable iff (!arst_n)
		res_strobe && final_res |-> state_q == ST_IDLE)
		else $error("run not ended after last force word");
	a_iter_done_wait: assert property (@(posedge clk) disable iff (!arst_n)
		irsp.done |-> state_q == ST_WT)
		else $error("iterative unit finished outside a wait");
	a_iter_go_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_WT |=> !ireq.go)
		else $error("iterative unit restarted while waiting");
`endif

endmodule

@@ sv/qapm_iter.sv @@
// iterative fixed-point divider and square root, one digit per cycle
module qapm_iter #(
	parameter int FRAC_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  qapm_pkg::iter_req_t  req,
	input  logic [31:0]          a,
	input  logic [31:0]          b,
	output qapm_pkg::iter_rsp_t  rsp,
	output logic [31:0]          result
);

	localparam int NB = 32 + FRAC_BITS;
	localparam int NP = (NB + 1) / 2;
	localparam int SW = 2 * NP;
	localparam int RW = (NP + 2 > 33) ? NP + 2 : 33;
	localparam int CW = $clog2(SW + 1);

	logic          busy_q;
	logic          sqrt_q;
	logic          neg_q;
	logic [CW-1:0] cnt_q;
	logic [SW-1:0] sh_q;
	logic [SW-1:0] quo_q;
	logic [RW-1:0] rem_q;
	logic [31:0]   dvs_q;
	logic          done_q;
	logic          sat_q;
	logic [31:0]   res_q;

	logic [31:0]   abs_a;
	logic [31:0]   abs_b;
	logic [RW-1:0] div_rem;
	logic          div_ge;
	logic [RW-1:0] sq_rem;
	logic [RW-1:0] sq_trial;
	logic          sq_ge;

	assign abs_a = a[31] ? (~a + 32'd1) : a;
	assign abs_b = b[31] ? (~b + 32'd1) : b;

	assign div_rem = {rem_q[RW-2:0], sh_q[SW-1]};
	assign div_ge = div_rem >= RW'(dvs_q);
	assign sq_rem = {rem_q[RW-3:0], sh_q[SW-1:SW-2]};
	assign sq_trial = {quo_q[RW-3:0], 2'b01};
	assign sq_ge = sq_rem >= sq_trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.go) begin
				if (req.sqrt_op ? ($signed(a) <= 0) : (b == 32'd0)) begin
					done_q <= 1'b1;
				end else begin
					busy_q <= 1'b1;
					cnt_q <= req.sqrt_op ? CW'(NP) : CW'(SW);
				end
			end else if (busy_q) begin
				if (cnt_q != '0) begin
					cnt_q <= cnt_q - CW'(1);
				end else begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.go) begin
			sqrt_q <= req.sqrt_op;
			neg_q <= a[31] ^ b[31];
			dvs_q <= abs_b;
			rem_q <= '0;
			quo_q <= '0;
			sat_q <= 1'b0;
			res_q <= '0;
			if (req.sqrt_op) begin
				sh_q <= SW'(a) << FRAC_BITS;
			end else begin
				sh_q <= SW'(abs_a) << FRAC_BITS;
				// zero divisor saturates by the sign of the dividend
				if (b == 32'd0) begin
					sat_q <= 1'b1;
					res_q <= a[31] ? 32'h8000_0000 :
						((a == 32'd0) ? 32'd0 : 32'h7FFF_FFFF);
				end
			end
		end else if (busy_q) begin
			if (cnt_q != '0) begin
				if (sqrt_q) begin
					sh_q <= {sh_q[SW-3:0], 2'b00};
					rem_q <= sq_ge ? (sq_rem - sq_trial) : sq_rem;
					quo_q <= {quo_q[SW-2:0], sq_ge};
				end else begin
					sh_q <= {sh_q[SW-2:0], 1'b0};
					rem_q <= div_ge ? (div_rem - RW'(dvs_q)) : div_rem;
					quo_q <= {quo_q[SW-2:0], div_ge};
				end
			end else if (sqrt_q) begin
				res_q <= quo_q[31:0];
			end else if (neg_q) begin
				if (quo_q > SW'(33'h0_8000_0000)) begin
					sat_q <= 1'b1;
					res_q <= 32'h8000_0000;
				end else begin
					res_q <= ~quo_q[31:0] + 32'd1;
				end
			end else begin
				if (quo_q > SW'(33'h0_7FFF_FFFF)) begin
					sat_q <= 1'b1;
					res_q <= 32'h7FFF_FFFF;
				end else begin
					res_q <= quo_q[31:0];
				end
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.sat = sat_q;
	assign result = res_q;

endmodule
